>>> hdl/dlrd_pkg.sv
`timescale 1ns / 1ps

package dlrd_pkg;

    localparam logic [1:0] KIND_LAT = 2'd0;
    localparam logic [1:0] KIND_LON = 2'd1;
    localparam logic [1:0] KIND_ALT = 2'd2;

    localparam logic [31:0] COORD_OFFSET = 32'h8000_0000;
    localparam logic [31:0] ALT_REF_CM   = 32'd10000000;

    // reciprocals: q = (x * K) >> S, exact for every 32-bit x (or stated width)
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;   // S = 41
    localparam logic [31:0] RECIP_100  = 32'd2748779070;   // S = 38
    localparam logic [22:0] RECIP_60A  = 23'd4473925;      // S = 28, x < 2^22
    localparam logic [16:0] RECIP_60B  = 17'd69906;        // S = 22, x < 2^16

    // 10^(e-2) metres for a code exponent e; e below 2 handled apart
    localparam logic [47:0] POW10_M [16] = '{
        48'd0, 48'd0, 48'd1, 48'd10, 48'd100, 48'd1000, 48'd10000, 48'd100000,
        48'd1000000, 48'd10000000, 48'd100000000, 48'd1000000000,
        48'd10000000000, 48'd100000000000, 48'd1000000000000,
        48'd10000000000000
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] raw;
        logic [47:0] size_m;
        logic [47:0] hprec_m;
        logic [47:0] vprec_m;
        logic        last;
    } dlrd_job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [25:0] whole;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [9:0]  fraction;
        logic        neg;
        logic [47:0] size_m;
        logic [47:0] hprec_m;
        logic [47:0] vprec_m;
        logic        last;
    } dlrd_res_t;

    function automatic logic [47:0] decode_code(input logic [7:0] code);
        logic [3:0]  mant;
        logic [3:0]  expo;
        logic [51:0] prod;
        logic [47:0] res;
        mant = code[7:4];
        expo = code[3:0];
        prod = 52'(mant) * 52'(POW10_M[expo]);
        if (expo == 4'd1)
        begin
            res = (mant >= 4'd10) ? 48'd1 : 48'd0;
        end
        else
        begin
            res = prod[47:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/dns_loc_record_decoder_unit.sv
`timescale 1ns / 1ps

// DNS LOC record decoder. Each record beat yields three result beats in the
// order latitude, longitude, altitude; size and precision codes are decoded to
// whole metres and repeated on all three. The single result channel carries
// one result a cycle unless the output stalls; the next record is taken when
// none is held or as the held record's altitude job issues. A held record and
// the five-stage result pipeline let the next record be taken while results
// still wait; a stalled output freezes the whole pipeline.
module dns_loc_record_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  size_code,
    input  logic [7:0]  horiz_prec_code,
    input  logic [7:0]  vert_prec_code,
    input  logic [31:0] latitude_raw,
    input  logic [31:0] longitude_raw,
    input  logic [31:0] altitude_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  coord_kind,
    output logic [25:0] whole_part,
    output logic [5:0]  arc_minutes,
    output logic [5:0]  arc_seconds,
    output logic [9:0]  fraction_part,
    output logic        is_negative,
    output logic [47:0] size_meters,
    output logic [47:0] horiz_prec_meters,
    output logic [47:0] vert_prec_meters,
    output logic        last_result
);

    logic                adv;
    logic                job_valid;
    dlrd_pkg::dlrd_job_t job;
    dlrd_pkg::dlrd_res_t res;

    assign adv = !out_valid || out_ready;

    dlrd_split u_split (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .size_code       (size_code),
        .horiz_prec_code (horiz_prec_code),
        .vert_prec_code  (vert_prec_code),
        .latitude_raw    (latitude_raw),
        .longitude_raw   (longitude_raw),
        .altitude_raw    (altitude_raw),
        .adv             (adv),
        .job_valid       (job_valid),
        .job             (job)
    );

    dlrd_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .job_valid (job_valid),
        .job       (job),
        .res_valid (out_valid),
        .res       (res)
    );

    assign coord_kind        = res.kind;
    assign whole_part        = res.whole;
    assign arc_minutes       = res.minutes;
    assign arc_seconds       = res.seconds;
    assign fraction_part     = res.fraction;
    assign is_negative       = res.neg;
    assign size_meters       = res.size_m;
    assign horiz_prec_meters = res.hprec_m;
    assign vert_prec_meters  = res.vprec_m;
    assign last_result       = res.last;

endmodule

>>> hdl/dlrd_split.sv
`timescale 1ns / 1ps

// holds one record and issues its three coordinate jobs, one per advance
module dlrd_split (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         size_code,
    input  logic [7:0]         horiz_prec_code,
    input  logic [7:0]         vert_prec_code,
    input  logic [31:0]        latitude_raw,
    input  logic [31:0]        longitude_raw,
    input  logic [31:0]        altitude_raw,
    input  logic               adv,
    output logic               job_valid,
    output dlrd_pkg::dlrd_job_t job
);

    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] lat_reg, lon_reg, alt_reg;
    logic [47:0] size_reg, hprec_reg, vprec_reg;
    logic        take;
    logic        issue_last;

    assign issue_last = adv && (idx_reg == dlrd_pkg::KIND_ALT);
    assign in_ready   = !busy_reg || issue_last;
    assign take       = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = dlrd_pkg::KIND_LAT;
        end
        else if (busy_reg && adv)
        begin
            if (issue_last)
            begin
                busy_next = 1'b0;
                idx_next  = dlrd_pkg::KIND_LAT;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= dlrd_pkg::KIND_LAT;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lat_reg   <= latitude_raw;
            lon_reg   <= longitude_raw;
            alt_reg   <= altitude_raw;
            size_reg  <= dlrd_pkg::decode_code(size_code);
            hprec_reg <= dlrd_pkg::decode_code(horiz_prec_code);
            vprec_reg <= dlrd_pkg::decode_code(vert_prec_code);
        end
    end

    always_comb
    begin
        job.kind    = idx_reg;
        job.size_m  = size_reg;
        job.hprec_m = hprec_reg;
        job.vprec_m = vprec_reg;
        job.last    = (idx_reg == dlrd_pkg::KIND_ALT);
        case (idx_reg)
            dlrd_pkg::KIND_LAT: job.raw = lat_reg;
            dlrd_pkg::KIND_LON: job.raw = lon_reg;
            default:            job.raw = alt_reg;
        endcase
    end

    assign job_valid = busy_reg;

endmodule

>>> hdl/dlrd_pipe.sv
`timescale 1ns / 1ps

// five stages: offset, /1000 or /100, /60, /60, remainders and output register
module dlrd_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               job_valid,
    input  dlrd_pkg::dlrd_job_t job,
    output logic               res_valid,
    output dlrd_pkg::dlrd_res_t res
);

    logic [4:0] v_reg, v_next;

    // stage 1
    dlrd_pkg::dlrd_job_t s1_reg;
    logic [31:0] s1_mag_reg, s1_mag_next;
    logic        s1_neg_next;
    // stage 2
    dlrd_pkg::dlrd_job_t s2_reg;
    logic [31:0] s2_mag_reg;
    logic [25:0] s2_q1_reg, s2_q1_next;
    logic [63:0] prod1;
    // stage 3
    dlrd_pkg::dlrd_job_t s3_reg;
    logic [25:0] s3_q1_reg;
    logic [9:0]  s3_frac_reg, s3_frac_next;
    logic [15:0] s3_q2_reg, s3_q2_next;
    logic [44:0] prod2;
    logic [35:0] back1;
    // stage 4
    dlrd_pkg::dlrd_job_t s4_reg;
    logic [25:0] s4_q1_reg;
    logic [9:0]  s4_frac_reg;
    logic [15:0] s4_q2_reg;
    logic [5:0]  s4_sec_reg, s4_sec_next;
    logic [9:0]  s4_q3_reg, s4_q3_next;
    logic [32:0] prod3;
    logic [21:0] back2;
    // stage 5
    dlrd_pkg::dlrd_res_t s5_reg, s5_next;
    logic [15:0] back3;
    logic        s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg;

    assign v_next = {v_reg[3:0], job_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        if (job.kind == dlrd_pkg::KIND_ALT)
        begin
            s1_neg_next = (job.raw < dlrd_pkg::ALT_REF_CM);
            s1_mag_next = s1_neg_next ? (dlrd_pkg::ALT_REF_CM - job.raw)
                                      : (job.raw - dlrd_pkg::ALT_REF_CM);
        end
        else
        begin
            s1_neg_next = (job.raw < dlrd_pkg::COORD_OFFSET);
            s1_mag_next = s1_neg_next ? (dlrd_pkg::COORD_OFFSET - job.raw)
                                      : (job.raw - dlrd_pkg::COORD_OFFSET);
        end
    end

    always_comb
    begin
        if (s1_reg.kind == dlrd_pkg::KIND_ALT)
        begin
            prod1      = 64'(s1_mag_reg) * 64'(dlrd_pkg::RECIP_100);
            s2_q1_next = prod1[63:38];
        end
        else
        begin
            prod1      = 64'(s1_mag_reg) * 64'(dlrd_pkg::RECIP_1000);
            s2_q1_next = 26'(prod1[63:41]);
        end
    end

    always_comb
    begin
        back1 = (s2_reg.kind == dlrd_pkg::KIND_ALT) ? 36'(s2_q1_reg) * 36'd100
                                                      : 36'(s2_q1_reg) * 36'd1000;
        s3_frac_next = s2_mag_reg[9:0] - back1[9:0];
        prod2        = 45'(s2_q1_reg[21:0]) * 45'(dlrd_pkg::RECIP_60A);
        s3_q2_next   = prod2[43:28];
    end

    always_comb
    begin
        back2       = 22'(s3_q2_reg) * 22'd60;
        s4_sec_next = s3_q1_reg[5:0] - back2[5:0];
        prod3       = 33'(s3_q2_reg) * 33'(dlrd_pkg::RECIP_60B);
        s4_q3_next  = prod3[31:22];
    end

    always_comb
    begin
        back3           = 16'(s4_q3_reg) * 16'd60;
        s5_next.kind    = s4_reg.kind;
        s5_next.neg     = s4_neg_reg;
        s5_next.size_m  = s4_reg.size_m;
        s5_next.hprec_m = s4_reg.hprec_m;
        s5_next.vprec_m = s4_reg.vprec_m;
        s5_next.last    = s4_reg.last;
        s5_next.fraction = s4_frac_reg;
        if (s4_reg.kind == dlrd_pkg::KIND_ALT)
        begin
            s5_next.whole   = s4_q1_reg;
            s5_next.minutes = 6'd0;
            s5_next.seconds = 6'd0;
        end
        else
        begin
            s5_next.whole   = 26'(s4_q3_reg);
            s5_next.minutes = s4_q2_reg[5:0] - back3[5:0];
            s5_next.seconds = s4_sec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= job;
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
            s2_reg      <= s1_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_q1_reg   <= s2_q1_next;
            s3_reg      <= s2_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_q1_reg   <= s2_q1_reg;
            s3_frac_reg <= s3_frac_next;
            s3_q2_reg   <= s3_q2_next;
            s4_reg      <= s3_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_q1_reg   <= s3_q1_reg;
            s4_frac_reg <= s3_frac_reg;
            s4_q2_reg   <= s3_q2_reg;
            s4_sec_reg  <= s4_sec_next;
            s4_q3_reg   <= s4_q3_next;
            s5_reg      <= s5_next;
        end
    end

    assign res_valid = v_reg[4];
    assign res       = s5_reg;

endmodule

>>> hdl/dlrd_checker.sv
`timescale 1ns / 1ps

module dlrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  coord_kind,
    input logic [5:0]  arc_minutes,
    input logic [5:0]  arc_seconds,
    input logic [9:0]  fraction_part,
    input logic        last_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_last_alt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_result == (coord_kind == dlrd_pkg::KIND_ALT)))
        else $error("last flag not on altitude beat");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (coord_kind != dlrd_pkg::KIND_ALT) |->
            (arc_minutes < 6'd60) && (arc_seconds < 6'd60) && (fraction_part < 10'd1000))
        else $error("angle field out of range");

    a_alt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (coord_kind == dlrd_pkg::KIND_ALT) |->
            (arc_minutes == 6'd0) && (arc_seconds == 6'd0) && (fraction_part < 10'd100))
        else $error("altitude beat fields wrong");

    a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (coord_kind == dlrd_pkg::KIND_LAT) ##1 out_valid |->
            (coord_kind == dlrd_pkg::KIND_LON))
        else $error("longitude beat does not follow latitude");

endmodule

bind dns_loc_record_decoder_unit dlrd_checker u_dlrd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .coord_kind    (coord_kind),
    .arc_minutes   (arc_minutes),
    .arc_seconds   (arc_seconds),
    .fraction_part (fraction_part),
    .last_result   (last_result)
);
